// ----- src/rafe_pkg.sv -----
// Shared constants, codes and helpers for the RGB565 fill engine.
// No dependencies; every other file of the block but rafe_ram imports this package.
package rafe_pkg;

   localparam int CW      = 10;   // coordinate width
   localparam int RW      = 9;    // radius width
   localparam int COLW    = 16;   // RGB565 word
   localparam int ALW     = 8;    // alpha width
   localparam int OPW     = 3;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam int SQ_IN_W  = 18;  // radius squared fits here
   localparam int SQ_OUT_W = 9;
   localparam int SQ_STEPS = 9;

   localparam int DIV_NUM_W = 18;
   localparam int DIV_DEN_W = 10;
   localparam int DIV_Q_W   = 8;

   localparam logic [OPW-1:0] OP_RECT   = 3'd0;
   localparam logic [OPW-1:0] OP_ROUND  = 3'd1;
   localparam logic [OPW-1:0] OP_GRAD   = 3'd2;
   localparam logic [OPW-1:0] OP_CIRCLE = 3'd3;
   localparam logic [OPW-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OPW-1:0] OP_READ   = 3'd5;

   localparam logic [1:0] REG_BYTE_SWAP = 2'd0;
   localparam logic [1:0] REG_MIRROR_X  = 2'd1;
   localparam logic [1:0] REG_MIRROR_Y  = 2'd2;

   localparam logic [ALW-1:0] ALPHA_OPAQUE = 8'd255;

   function automatic logic [COLW-1:0] swap_bytes(input logic [COLW-1:0] v);
      return {v[7:0], v[15:8]};
   endfunction

endpackage

// ----- src/rafe_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rafe_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 76800,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rafe_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on rafe_pkg.
module rafe_isqrt
   import rafe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQ_IN_W-1:0]  value,
   output logic                busy,
   output logic [SQ_OUT_W-1:0] root
);

   logic                busy_ff, busy_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [SQ_IN_W-1:0]  rem_ff, rem_in;
   logic [SQ_IN_W:0]    root_ff, root_in;
   logic [SQ_IN_W-1:0]  bit_ff, bit_in;
   logic [SQ_IN_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      trial   = root_ff + {1'b0, bit_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'(SQ_STEPS - 1);
         rem_in  = value;
         root_in = '0;
         bit_in  = SQ_IN_W'(1) << (SQ_IN_W - 2);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[SQ_IN_W-1:0];
            root_in = (root_ff >> 1) + {1'b0, bit_ff};
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign busy = busy_ff;
   assign root = root_ff[SQ_OUT_W-1:0];

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("square root started while busy");

endmodule

// ----- src/rafe_div.sv -----
// Restoring divider for the gradient weight, one quotient bit per cycle.
// Depends on rafe_pkg; the quotient must fit in eight bits.
module rafe_div
   import rafe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 busy,
   output logic [DIV_Q_W-1:0]   quot
);

   logic                 busy_ff, busy_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'(DIV_Q_W - 1);
         rem_in  = num;
         dsh_in  = DIV_NUM_W'(den) << (DIV_Q_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[DIV_Q_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ----- src/rafe_blend.sv -----
// Per-channel RGB565 alpha blend, products registered, result in the next cycle.
// Depends on rafe_pkg.
module rafe_blend
   import rafe_pkg::*;
(
   input  logic            clock,
   input  logic [COLW-1:0] bg,
   input  logic [COLW-1:0] fg,
   input  logic [ALW-1:0]  alpha,
   output logic [COLW-1:0] mix
);

   logic [13:0]     sum_r_ff, sum_g_ff, sum_b_ff;
   logic [13:0]     sum_r_in, sum_g_in, sum_b_in;
   logic            full_ff, zero_ff;
   logic [COLW-1:0] fg_ff, bg_ff;
   logic [ALW-1:0]  inv;
   logic [5:0]      q_r, q_g, q_b;

   // Exact x/255 for x below 16320, the range where the quotient fits in six bits.
   function automatic logic [5:0] div255(input logic [13:0] x);
      logic [14:0] y;
      logic [14:0] q;
      y = {1'b0, x} + 15'd1;
      q = (y + (y >> 8)) >> 8;
      return q[5:0];
   endfunction

   always_comb begin
      inv      = ALPHA_OPAQUE - alpha;
      sum_r_in = 14'(fg[15:11] * alpha) + 14'(bg[15:11] * inv);
      sum_g_in = 14'(fg[10:5] * alpha) + 14'(bg[10:5] * inv);
      sum_b_in = 14'(fg[4:0] * alpha) + 14'(bg[4:0] * inv);
   end

   always_ff @(posedge clock) begin
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
      full_ff  <= (alpha == ALPHA_OPAQUE);
      zero_ff  <= (alpha == '0);
      fg_ff    <= fg;
      bg_ff    <= bg;
   end

   always_comb begin
      q_r = div255(sum_r_ff);
      q_g = div255(sum_g_ff);
      q_b = div255(sum_b_ff);
      if (full_ff) begin
         mix = fg_ff;
      end else if (zero_ff) begin
         mix = bg_ff;
      end else begin
         mix = {q_r[4:0], q_g, q_b[4:0]};
      end
   end

endmodule

// ----- src/rgb565_alpha_fill_engine.sv -----
// Top level of the RGB565 fill engine: command sequencer, frame RAM, CSRs.
// Depends on rafe_pkg, rafe_ram, rafe_isqrt, rafe_div and rafe_blend.
//
//  channel | ports                         | transfer when
//  req     | req_valid/req_ready + fields  | req_valid && req_ready
//  rsp     | rsp_valid/rsp_ready + fields  | rsp_valid && rsp_ready
//  csr     | APB psel/penable/pwrite/...   | psel && penable && pwrite (write)
//
// Steps: opaque pixels go through address and write, blended ones through address,
// read, blend and write on one RAM port pair; each row passes the row and root states,
// a gradient row also the gradient and capture states; the root state waits while the
// square root or the divider runs. Clear writes each frame word in turn.
// One command is processed at a time; req_ready is high only when idle.
// A finished result waits in the output register while the next command runs.
// Reset is synchronous; the frame contents are undefined until written.
module rgb565_alpha_fill_engine
   import rafe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 320
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OPW-1:0]     req_opcode,
   input  logic [CW-1:0]      req_left_x,
   input  logic [CW-1:0]      req_top_y,
   input  logic [CW-1:0]      req_right_x,
   input  logic [CW-1:0]      req_bottom_y,
   input  logic [CW-1:0]      req_center_x,
   input  logic [CW-1:0]      req_center_y,
   input  logic [RW-1:0]      req_radius,
   input  logic [COLW-1:0]    req_fill_color,
   input  logic [COLW-1:0]    req_end_color,
   input  logic [ALW-1:0]     req_alpha,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COLW-1:0]    rsp_pixel_data,
   output logic               rsp_read_valid,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0] XMAX  = CW'(SCREEN_WIDTH - 1);
   localparam logic [CW-1:0] YMAX  = CW'(SCREEN_HEIGHT - 1);
   localparam logic [AW-1:0] ALAST = AW'(DEPTH - 1);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_SETUP = 16'h0002,
      ST_SQR   = 16'h0004,
      ST_ROW   = 16'h0008,
      ST_ROOT  = 16'h0010,
      ST_GRAD  = 16'h0020,
      ST_GCAP  = 16'h0040,
      ST_PIX   = 16'h0080,
      ST_RD    = 16'h0100,
      ST_MIX   = 16'h0200,
      ST_WR    = 16'h0400,
      ST_CLEAR = 16'h0800,
      ST_RADDR = 16'h1000,
      ST_RWAIT = 16'h2000,
      ST_RDATA = 16'h4000,
      ST_DONE  = 16'h8000
   } state_type;

   state_type         state_ff, state_in;
   logic              byte_swap_ff, byte_swap_in;
   logic              mirror_x_ff, mirror_x_in;
   logic              mirror_y_ff, mirror_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COLW-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_read_ff, rsp_read_in;

   logic [OPW-1:0]    op_ff, op_in;
   logic [CW-1:0]     x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [RW-1:0]     r_ff, r_in, rc_ff, rc_in;
   logic [SQ_IN_W-1:0] r_sq_ff, r_sq_in;
   logic [COLW-1:0]   c0_ff, c0_in, c1_ff, c1_in, color_ff, color_in;
   logic [ALW-1:0]    alpha_ff, alpha_in;
   logic              opaque_ff, opaque_in, flat_ff, flat_in, corner_ff, corner_in;
   logic [CW-1:0]     x_ff, x_in, x_end_ff, x_end_in, y_ff, y_in, y_end_ff, y_end_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [COLW-1:0]   rd_pix_ff, rd_pix_in;

   logic              accept, csr_write;
   logic              ram_we;
   logic [COLW-1:0]   ram_wdata, ram_rdata, pix_word;
   logic [COLW-1:0]   blend_bg, blend_fg, blend_mix;
   logic [ALW-1:0]    blend_alpha;
   logic              sq_start, sq_busy, div_start, div_busy;
   logic [SQ_IN_W-1:0] sq_value;
   logic [SQ_OUT_W-1:0] sq_root;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_Q_W-1:0] div_quot;

   logic [CW-1:0]     fx, fy, half, dd, d_top, d_bot, span;
   logic [CW:0]       height;
   logic [RW-1:0]     diff, inset;
   logic signed [CW+1:0] ys, dy, xa;
   logic [CW+1:0]     ye, xb;
   logic [CW-1:0]     ys_c, ye_c, xa_c, xb_c, ady;
   logic [2*CW-1:0]   dsq;
   logic [SQ_IN_W-1:0] dif_sq;
   logic              row_last, pix_last;
   state_type         row_next;

   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite;
   assign req_ready = (state_ff == ST_IDLE);

   rafe_ram #(.WIDTH(COLW), .DEPTH(DEPTH), .ADDR_W(AW)) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (addr_ff),
      .wdata   (ram_wdata),
      .raddr   (addr_ff),
      .rd_data (ram_rdata)
   );

   rafe_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   rafe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (y1_ff - y0_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   rafe_blend u_blend (
      .clock (clock),
      .bg    (blend_bg),
      .fg    (blend_fg),
      .alpha (blend_alpha),
      .mix   (blend_mix)
   );

   // Datapath terms shared by several states.
   always_comb begin
      fx     = mirror_x_ff ? XMAX - x_ff : x_ff;
      fy     = mirror_y_ff ? YMAX - y_ff : y_ff;
      height = {1'b0, y1_ff} - {1'b0, y0_ff} + 11'd1;
      half   = height[CW:1];
      d_top  = y_ff - y0_ff;
      d_bot  = y1_ff - y_ff;
      dd     = (d_top < d_bot) ? d_top : d_bot;
      diff   = rc_ff - dd[RW-1:0];
      dif_sq = SQ_IN_W'(diff * diff);
      span   = x1_ff - x0_ff;
      inset  = corner_ff ? rc_ff - sq_root : '0;

      ys   = $signed({2'b00, cy_ff}) - $signed({3'b000, r_ff});
      ye   = {2'b00, cy_ff} + {3'b000, r_ff};
      ys_c = ys[CW+1] ? '0 : ys[CW-1:0];
      ye_c = (ye > {2'b00, YMAX}) ? YMAX : ye[CW-1:0];
      dy   = $signed({2'b00, y_ff}) - $signed({2'b00, cy_ff});
      ady  = dy[CW+1] ? CW'(-dy) : dy[CW-1:0];
      dsq  = ady * ady;
      xa   = $signed({2'b00, cx_ff}) - $signed({3'b000, sq_root});
      xb   = {2'b00, cx_ff} + {3'b000, sq_root};
      xa_c = xa[CW+1] ? '0 : xa[CW-1:0];
      xb_c = (xb > {2'b00, XMAX}) ? XMAX : xb[CW-1:0];

      row_last = (y_ff == y_end_ff);
      pix_last = (x_ff == x_end_ff);
      row_next = row_last ? ST_DONE : ST_ROW;

      pix_word  = opaque_ff ? color_ff : blend_mix;
      ram_we    = (state_ff == ST_WR) || (state_ff == ST_CLEAR);
      ram_wdata = (state_ff == ST_CLEAR) ? color_ff : pix_word;
      if (byte_swap_ff) begin
         ram_wdata = swap_bytes(ram_wdata);
      end

      if (state_ff == ST_GRAD) begin
         blend_bg    = c0_ff;
         blend_fg    = c1_ff;
         blend_alpha = flat_ff ? '0 : div_quot;
      end else begin
         blend_bg    = byte_swap_ff ? swap_bytes(ram_rdata) : ram_rdata;
         blend_fg    = color_ff;
         blend_alpha = alpha_ff;
      end

      if (op_ff == OP_CIRCLE) begin
         sq_value = SQ_IN_W'({2'b00, r_sq_ff} - dsq);
      end else begin
         sq_value = r_sq_ff - dif_sq;
      end
      div_num   = DIV_NUM_W'({d_top, 8'd0} - {8'd0, d_top});
      sq_start  = (state_ff == ST_ROW) && ((op_ff == OP_CIRCLE) || (dd < {1'b0, rc_ff}));
      div_start = (state_ff == ST_ROW) && (op_ff == OP_GRAD) && !flat_ff;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      r_in      = r_ff;
      rc_in     = rc_ff;
      r_sq_in   = r_sq_ff;
      c0_in     = c0_ff;
      c1_in     = c1_ff;
      color_in  = color_ff;
      alpha_in  = alpha_ff;
      opaque_in = opaque_ff;
      flat_in   = flat_ff;
      corner_in = corner_ff;
      x_in      = x_ff;
      x_end_in  = x_end_ff;
      y_in      = y_ff;
      y_end_in  = y_end_ff;
      addr_in   = addr_ff;
      rd_pix_in = rd_pix_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_read_in  = rsp_read_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               x0_in     = req_left_x;
               y0_in     = req_top_y;
               x1_in     = (req_right_x > XMAX) ? XMAX : req_right_x;
               y1_in     = (req_bottom_y > YMAX) ? YMAX : req_bottom_y;
               cx_in     = req_center_x;
               cy_in     = req_center_y;
               r_in      = req_radius;
               c0_in     = req_fill_color;
               c1_in     = req_end_color;
               color_in  = req_fill_color;
               alpha_in  = req_alpha;
               opaque_in = (req_alpha == ALPHA_OPAQUE) || (req_opcode == OP_GRAD);
               x_in      = req_left_x;
               y_in      = req_top_y;
               addr_in   = '0;
               case (req_opcode)
                  OP_RECT, OP_ROUND, OP_GRAD, OP_CIRCLE: state_in = ST_SETUP;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_READ:  state_in = ST_RADDR;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SETUP: begin
            if (op_ff == OP_CIRCLE) begin
               rc_in    = r_ff;
               y_in     = ys_c;
               y_end_in = ye_c;
               state_in = (ys_c > ye_c) ? ST_DONE : ST_SQR;
            end else begin
               if (op_ff == OP_RECT) begin
                  rc_in = '0;
               end else begin
                  rc_in = ({1'b0, r_ff} > half) ? half[RW-1:0] : r_ff;
               end
               flat_in  = (y1_ff == y0_ff);
               y_in     = y0_ff;
               y_end_in = y1_ff;
               state_in = ((x1_ff < x0_ff) || (y1_ff < y0_ff)) ? ST_DONE : ST_SQR;
            end
         end
         ST_SQR: begin
            r_sq_in  = rc_ff * rc_ff;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            corner_in = (dd < {1'b0, rc_ff});
            state_in  = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sq_busy && !div_busy) begin
               if (op_ff == OP_CIRCLE) begin
                  x_in     = xa_c;
                  x_end_in = xb_c;
                  if (xb_c < xa_c) begin
                     state_in = row_next;
                     y_in     = y_ff + 10'd1;
                  end else begin
                     state_in = ST_PIX;
                  end
               end else begin
                  x_in     = x0_ff + {1'b0, inset};
                  x_end_in = x1_ff - {1'b0, inset};
                  if ({1'b0, inset, 1'b0} > {1'b0, span}) begin
                     state_in = row_next;
                     y_in     = y_ff + 10'd1;
                  end else begin
                     state_in = (op_ff == OP_GRAD) ? ST_GRAD : ST_PIX;
                  end
               end
            end
         end
         ST_GRAD: state_in = ST_GCAP;
         ST_GCAP: begin
            color_in = blend_mix;
            state_in = ST_PIX;
         end
         ST_PIX: begin
            addr_in  = AW'(32'(fy) * 32'(SCREEN_WIDTH) + 32'(fx));
            state_in = opaque_ff ? ST_WR : ST_RD;
         end
         ST_RD:  state_in = ST_MIX;
         ST_MIX: state_in = ST_WR;
         ST_WR: begin
            if (pix_last) begin
               state_in = row_next;
               y_in     = y_ff + 10'd1;
            end else begin
               x_in     = x_ff + 10'd1;
               state_in = ST_PIX;
            end
         end
         ST_CLEAR: begin
            if (addr_ff == ALAST) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_RADDR: begin
            addr_in = AW'(32'(fy) * 32'(SCREEN_WIDTH) + 32'(fx));
            if ((x_ff > XMAX) || (y_ff > YMAX)) begin
               rd_pix_in = '0;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: state_in = ST_RDATA;
         ST_RDATA: begin
            rd_pix_in = byte_swap_ff ? swap_bytes(ram_rdata) : ram_rdata;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = (op_ff == OP_READ) ? rd_pix_ff : '0;
               rsp_read_in  = (op_ff == OP_READ);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration registers.
   always_comb begin
      byte_swap_in = byte_swap_ff;
      mirror_x_in  = mirror_x_ff;
      mirror_y_in  = mirror_y_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_BYTE_SWAP: byte_swap_in = pwdata[0];
            REG_MIRROR_X:  mirror_x_in  = pwdata[0];
            REG_MIRROR_Y:  mirror_y_in  = pwdata[0];
            default: ;
         endcase
      end
      case (paddr[3:2])
         REG_BYTE_SWAP: prdata = {31'd0, byte_swap_ff};
         REG_MIRROR_X:  prdata = {31'd0, mirror_x_ff};
         REG_MIRROR_Y:  prdata = {31'd0, mirror_y_ff};
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_swap_ff <= 1'b0;
         mirror_x_ff  <= 1'b0;
         mirror_y_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_swap_ff <= byte_swap_in;
         mirror_x_ff  <= mirror_x_in;
         mirror_y_ff  <= mirror_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_read_ff  <= rsp_read_in;
      op_ff     <= op_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      r_ff      <= r_in;
      rc_ff     <= rc_in;
      r_sq_ff   <= r_sq_in;
      c0_ff     <= c0_in;
      c1_ff     <= c1_in;
      color_ff  <= color_in;
      alpha_ff  <= alpha_in;
      opaque_ff <= opaque_in;
      flat_ff   <= flat_in;
      corner_ff <= corner_in;
      x_ff      <= x_in;
      x_end_ff  <= x_end_in;
      y_ff      <= y_in;
      y_end_ff  <= y_end_in;
      addr_ff   <= addr_in;
      rd_pix_ff <= rd_pix_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_data = rsp_pixel_ff;
   assign rsp_read_valid = rsp_read_ff;

   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   assert property (@(posedge clock) disable iff (reset) ram_we |-> addr_ff <= ALAST)
      else $error("frame write outside the frame");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> (x_ff <= x_end_ff) && (x_end_ff <= XMAX) && (y_ff <= YMAX))
      else $error("pixel walk left the span");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> $past(state_ff) == ST_RD)
      else $error("blend without a preceding frame read");

endmodule

// ----- sim/rgb565_alpha_fill_engine_test.sv -----
// Self-checking testbench for rgb565_alpha_fill_engine: a directed table of commands
// then random ones; checks use a behavioral frame-buffer predictor or typed values.
// Depends on rafe_pkg and the engine RTL only.
module rgb565_alpha_fill_engine_test
   import rafe_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FW = 240;
   localparam int FH = 320;

   typedef struct {
      logic [OPW-1:0]  op;
      logic [CW-1:0]   lx, ty, rx, by, cx, cy;
      logic [RW-1:0]   rad;
      logic [COLW-1:0] c0, c1;
      logic [ALW-1:0]  a;
   } cmd_type;

   typedef struct {
      logic [COLW-1:0] pix;
      logic            rd;
   } answer_type;

   typedef struct {
      cmd_type         c;
      bit              typed;
      logic [COLW-1:0] pix;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [OPW-1:0] req_opcode = '0;
   logic [CW-1:0] req_left_x = '0, req_top_y = '0, req_right_x = '0, req_bottom_y = '0;
   logic [CW-1:0] req_center_x = '0, req_center_y = '0;
   logic [RW-1:0] req_radius = '0;
   logic [COLW-1:0] req_fill_color = '0, req_end_color = '0;
   logic [ALW-1:0] req_alpha = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [COLW-1:0] rsp_pixel_data;
   logic rsp_read_valid;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   rgb565_alpha_fill_engine dut (.*);

   always #1 clock = ~clock;

   // Predictor state: the frame as the engine stores it, and the register copies.
   logic [COLW-1:0] frame_mem [0:FW*FH-1];
   bit swap_on, flip_x, flip_y;
   answer_type pending_answers[$];
   int errors = 0;
   bit calm = 0;
   bit hold_request = 0;
   int stall_left = 0;

   function automatic int unsigned frame_index(int unsigned x, int unsigned y);
      int unsigned fx, fy;
      fx = flip_x ? FW - 1 - x : x;
      fy = flip_y ? FH - 1 - y : y;
      return fy * FW + fx;
   endfunction

   function automatic logic [COLW-1:0] peek_pixel(int unsigned x, int unsigned y);
      logic [COLW-1:0] v;
      if (x >= FW || y >= FH) return '0;
      v = frame_mem[frame_index(x, y)];
      return swap_on ? {v[7:0], v[15:8]} : v;
   endfunction

   function automatic void poke_pixel(int unsigned x, int unsigned y, logic [COLW-1:0] c);
      if (x >= FW || y >= FH) return;
      frame_mem[frame_index(x, y)] = swap_on ? {c[7:0], c[15:8]} : c;
   endfunction

   function automatic logic [COLW-1:0] blend565(logic [COLW-1:0] bg, logic [COLW-1:0] fg,
                                                int unsigned a);
      int unsigned r, g, b, na;
      if (a >= 255) return fg;
      if (a == 0) return bg;
      na = 255 - a;
      r = (fg[15:11] * a + bg[15:11] * na) / 255;
      g = (fg[10:5] * a + bg[10:5] * na) / 255;
      b = (fg[4:0] * a + bg[4:0] * na) / 255;
      return {r[4:0], g[5:0], b[4:0]};
   endfunction

   function automatic int unsigned root_floor(int unsigned v);
      int unsigned rem, root, b;
      rem = v;
      root = 0;
      b = 32'h4000_0000;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic void draw_box(int unsigned x0, int unsigned y0, int unsigned x1,
                                    int unsigned y1, logic [COLW-1:0] c, int unsigned a);
      if (x1 >= FW) x1 = FW - 1;
      if (y1 >= FH) y1 = FH - 1;
      for (int unsigned y = y0; y <= y1; y++)
         for (int unsigned x = x0; x <= x1; x++)
            poke_pixel(x, y, a >= 255 ? c : blend565(peek_pixel(x, y), c, a));
   endfunction

   function automatic void draw_rounded(int unsigned x0, int unsigned y0, int unsigned x1,
                                        int unsigned y1, int unsigned r, logic [COLW-1:0] ct,
                                        logic [COLW-1:0] cb, bit grad, int unsigned a);
      int unsigned h, d, d2, dd, inset, w;
      if (x1 >= FW) x1 = FW - 1;
      if (y1 >= FH) y1 = FH - 1;
      if (x1 < x0 || y1 < y0) return;
      h = y1 - y0 + 1;
      if (r > h / 2) r = h / 2;
      for (int unsigned y = y0; y <= y1; y++) begin
         d = y - y0;
         d2 = y1 - y;
         dd = d < d2 ? d : d2;
         inset = 0;
         if (dd < r) inset = r - root_floor(r * r - (r - dd) * (r - dd));
         if (2 * inset > x1 - x0) continue;
         if (grad) begin
            // A one-row shape has no span to interpolate over and keeps the top color.
            w = (y1 == y0) ? 0 : ((y - y0) * 255) / (y1 - y0);
            draw_box(x0 + inset, y, x1 - inset, y, blend565(ct, cb, w), 255);
         end else begin
            draw_box(x0 + inset, y, x1 - inset, y, ct, a);
         end
      end
   endfunction

   function automatic void draw_disc(int cx, int cy, int r, logic [COLW-1:0] c,
                                     int unsigned a);
      int row, hw, xa, xb;
      for (int dy = -r; dy <= r; dy++) begin
         row = cy + dy;
         hw = root_floor(r * r - dy * dy);
         xa = cx - hw;
         xb = cx + hw;
         if (row < 0 || row >= FH) continue;
         if (xa < 0) xa = 0;
         if (xb >= FW) xb = FW - 1;
         if (xb < xa) continue;
         draw_box(xa, row, xb, row, c, a);
      end
   endfunction

   function automatic answer_type run_command(cmd_type c);
      answer_type res;
      res.pix = '0;
      res.rd = 1'b0;
      case (c.op)
         OP_RECT:   draw_box(c.lx, c.ty, c.rx, c.by, c.c0, c.a);
         OP_ROUND:  draw_rounded(c.lx, c.ty, c.rx, c.by, c.rad, c.c0, c.c0, 0, c.a);
         OP_GRAD:   draw_rounded(c.lx, c.ty, c.rx, c.by, c.rad, c.c0, c.c1, 1, 255);
         OP_CIRCLE: draw_disc(c.cx, c.cy, c.rad, c.c0, c.a);
         OP_CLEAR:
            for (int i = 0; i < FW * FH; i++)
               frame_mem[i] = swap_on ? {c.c0[7:0], c.c0[15:8]} : c.c0;
         OP_READ: begin
            res.pix = peek_pixel(c.lx, c.ty);
            res.rd = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic cmd_type mk(logic [OPW-1:0] op, int lx, int ty, int rx, int by,
                                  int cx, int cy, int r, int c0, int c1, int a);
      cmd_type c;
      c.op = op; c.lx = CW'(lx); c.ty = CW'(ty); c.rx = CW'(rx); c.by = CW'(by);
      c.cx = CW'(cx); c.cy = CW'(cy);
      c.rad = RW'(r); c.c0 = COLW'(c0); c.c1 = COLW'(c1); c.a = ALW'(a);
      return c;
   endfunction

   function automatic row_type chk(cmd_type c, logic [COLW-1:0] pix);
      row_type t;
      t.c = c; t.typed = 1; t.pix = pix;
      return t;
   endfunction

   function automatic row_type prd(cmd_type c);
      row_type t;
      t.c = c; t.typed = 0; t.pix = '0;
      return t;
   endfunction

   // Enters at a falling edge and returns at the falling edge after the transfer,
   // with req_valid still high; the caller drives the next item or idles the channel.
   task automatic send_command(cmd_type c, bit typed, logic [COLW-1:0] pix);
      answer_type want;
      if (!calm && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= c.op;
      req_left_x <= c.lx; req_top_y <= c.ty; req_right_x <= c.rx; req_bottom_y <= c.by;
      req_center_x <= c.cx; req_center_y <= c.cy; req_radius <= c.rad;
      req_fill_color <= c.c0; req_end_color <= c.c1; req_alpha <= c.a;
      do @(posedge clock); while (!req_ready);
      want = run_command(c);
      if (typed) want.pix = pix;
      pending_answers.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, bit v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= PADDR_W'({idx, 2'b00}); pwdata <= PDATA_W'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_BYTE_SWAP: swap_on = v;
         REG_MIRROR_X:  flip_x = v;
         default:       flip_y = v;
      endcase
   endtask

   function automatic cmd_type random_command();
      cmd_type c;
      int unsigned pick;
      c = mk(OP_RECT, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 255));
      if ($urandom_range(0, 99) < 25) c.a = ALW'(($urandom_range(0, 1) == 1) ? 255 : 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) c.op = OP_CLEAR;
      else if (pick < 22) c.op = OP_READ;
      else if (pick < 42) c.op = OP_RECT;
      else if (pick < 60) c.op = OP_ROUND;
      else if (pick < 78) c.op = OP_GRAD;
      else c.op = OP_CIRCLE;
      if ($urandom_range(0, 99) < 15) begin
         // Wide values: far corners may run off the screen; near corners sit close to
         // the bottom-right edge so that clipped shapes stay cheap.
         c.lx = CW'($urandom_range(200, 1023));
         c.ty = CW'($urandom_range(290, 1023));
         c.rx = CW'($urandom_range(0, 1023));
         c.by = CW'($urandom_range(0, 1023));
         c.rad = RW'($urandom_range(0, 511));
         c.cx = CW'($urandom_range(0, 1023));
         c.cy = CW'($urandom_range(0, 1023));
         if (c.rad > 40) c.cx = CW'($urandom_range(600, 1023));
         if (c.op == OP_READ) begin
            c.lx = CW'($urandom_range(0, 1023));
            c.ty = CW'($urandom_range(0, 1023));
         end
      end else begin
         c.lx = CW'($urandom_range(0, FW - 1));
         c.ty = CW'($urandom_range(0, FH - 1));
         c.rx = CW'(c.lx + $urandom_range(0, 24));
         c.by = CW'(c.ty + $urandom_range(0, 24));
         if ($urandom_range(0, 9) == 0) c.rx = CW'(c.lx - 1);
         c.rad = RW'($urandom_range(0, 14));
         c.cx = CW'($urandom_range(0, FW - 1));
         c.cy = CW'($urandom_range(0, FH - 1));
      end
      return c;
   endfunction

   // Result checking; a long hold-off starts here when the sender asks for one.
   always @(posedge clock) begin
      answer_type want;
      if (hold_request) begin
         hold_request = 0;
         stall_left = 400;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result transfer: pixel_data %h", rsp_pixel_data);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_pixel_data !== want.pix) begin
               $error("pixel_data: expected %h, got %h", want.pix, rsp_pixel_data);
               errors++;
            end
            if (rsp_read_valid !== want.rd) begin
               $error("read_valid: expected %b, got %b", want.rd, rsp_read_valid);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= calm || $urandom_range(0, 99) >= 35;
      end
   end

   initial begin
      #20_000_000;
      $display("rgb565_alpha_fill_engine_test: done, errors");
      $finish;
   end

   initial begin
      row_type plan[$];
      bit settings[4][3] = '{'{0, 0, 0}, '{1, 1, 1}, '{1, 0, 1}, '{0, 1, 0}};
      plan = '{
         chk(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 0, 0), 16'h0000),
         chk(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 16'h1234),
         chk(mk(OP_READ, 239, 319, 0, 0, 0, 0, 0, 0, 0, 0), 16'h1234),
         chk(mk(OP_READ, 240, 0, 0, 0, 0, 0, 0, 0, 0, 0), 16'h0000),
         chk(mk(OP_READ, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0), 16'h0000),
         prd(mk(OP_RECT, 10, 10, 20, 20, 0, 0, 0, 16'hF800, 0, 255)),
         chk(mk(OP_READ, 15, 15, 0, 0, 0, 0, 0, 0, 0, 0), 16'hF800),
         prd(mk(OP_RECT, 12, 12, 30, 30, 0, 0, 0, 16'h07E0, 0, 128)),
         prd(mk(OP_RECT, 25, 25, 35, 35, 0, 0, 0, 16'hFFFF, 0, 0)),
         prd(mk(OP_RECT, 50, 10, 40, 20, 0, 0, 0, 16'hFFFF, 0, 255)),
         prd(mk(OP_RECT, 230, 310, 1023, 1023, 0, 0, 0, 16'h001F, 0, 255)),
         chk(mk(OP_READ, 239, 319, 0, 0, 0, 0, 0, 0, 0, 0), 16'h001F),
         prd(mk(OP_ROUND, 40, 40, 100, 80, 0, 0, 10, 16'hA5A5, 0, 200)),
         prd(mk(OP_ROUND, 60, 100, 62, 140, 0, 0, 20, 16'h5A5A, 0, 255)),
         prd(mk(OP_ROUND, 100, 10, 150, 15, 0, 0, 511, 16'hFFE0, 0, 1)),
         prd(mk(OP_GRAD, 20, 150, 120, 200, 0, 0, 8, 16'h0000, 16'hFFFF, 7)),
         prd(mk(OP_GRAD, 20, 210, 120, 210, 0, 0, 3, 16'hF81F, 16'h07E0, 0)),
         prd(mk(OP_CIRCLE, 0, 0, 0, 0, 120, 160, 30, 16'h7BEF, 0, 255)),
         prd(mk(OP_CIRCLE, 0, 0, 0, 0, 5, 5, 20, 16'hFFFF, 0, 100)),
         prd(mk(OP_CIRCLE, 0, 0, 0, 0, 200, 300, 0, 16'h8410, 0, 254)),
         prd(mk(OP_CIRCLE, 0, 0, 0, 0, 1023, 1023, 511, 16'hFFFF, 0, 255)),
         prd(mk(OP_READ, 120, 160, 0, 0, 0, 0, 0, 0, 0, 0)),
         prd(mk(OP_READ, 60, 45, 0, 0, 0, 0, 0, 0, 0, 0)),
         prd(mk(OP_READ, 70, 180, 0, 0, 0, 0, 0, 0, 0, 0))
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      swap_on = 0; flip_x = 0; flip_y = 0;
      foreach (plan[i]) send_command(plan[i].c, plan[i].typed, plan[i].pix);
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         csr_write(REG_BYTE_SWAP, settings[ph][0]);
         csr_write(REG_MIRROR_X, settings[ph][1]);
         csr_write(REG_MIRROR_Y, settings[ph][2]);
         calm = (ph == 1);
         for (int n = 0; n < 20; n++) begin
            if (ph == 2 && n == 3) hold_request = 1;
            if (ph == 3 && n == 12) drain();
            send_command(random_command(), 0, '0);
         end
      end
      calm = 0;
      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("rgb565_alpha_fill_engine_test: done, clean");
      end else begin
         $display("rgb565_alpha_fill_engine_test: done, errors");
      end
      $finish;
   end

endmodule
